>>> design/tbm_pkg.sv
// Shared types, constants and the per-row popcount step for the ternary by binary tile MAC.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tbm_pkg;

    localparam int PLANE_W       = 32;
    localparam int BYTE_W        = 8;
    localparam int PLANE_ROWS    = PLANE_W / BYTE_W;
    localparam int ACC_W         = 16;
    localparam int DELTA_W       = 5;
    localparam int COL_W         = 6;
    localparam int ROW_W         = 2;
    localparam int DEF_TILE_ROWS = 4;
    localparam int DEF_TILE_COLS = 64;

    localparam logic CMD_ACC   = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic [ACC_W-1:0] acc_t;

    typedef struct packed {
        acc_t             sum;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } result_t;

    localparam delta_t DELTA_ONE = delta_t'(1);

    // Each element adds +1 when it agrees with B, -1 when it disagrees, and
    // nothing when neither or both plane bits are set.
    function automatic delta_t byte_delta(input logic [BYTE_W-1:0] p,
                                          input logic [BYTE_W-1:0] n,
                                          input logic [BYTE_W-1:0] b);
        delta_t d;
        d = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (p[i] && !n[i])
            begin
                d = b[i] ? d - DELTA_ONE : d + DELTA_ONE;
            end
            else if (n[i] && !p[i])
            begin
                d = b[i] ? d + DELTA_ONE : d - DELTA_ONE;
            end
        end
        return d;
    endfunction

endpackage

>>> design/tbm_in_if.sv
// Input channel of the tile MAC: valid/ready handshake and the command item.
// Depends on tbm_pkg.
`timescale 1ns / 1ps

interface tbm_in_if;
    import tbm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic [PLANE_W-1:0]   a_pos;
    logic [PLANE_W-1:0]   a_neg;
    logic [BYTE_W-1:0]    b_neg;

    modport source (output valid, cmd, col, row, a_pos, a_neg, b_neg, input ready);
    modport sink   (input valid, cmd, col, row, a_pos, a_neg, b_neg, output ready);
endinterface

>>> design/tbm_out_if.sv
// Result channel of the tile MAC: valid/ready handshake and the drained entry.
// Depends on tbm_pkg.
`timescale 1ns / 1ps

interface tbm_out_if;
    import tbm_pkg::*;

    logic                valid;
    logic                ready;
    logic signed [ACC_W-1:0] sum;
    logic [ROW_W-1:0]    out_row;
    logic [COL_W-1:0]    out_col;

    modport source (output valid, sum, out_row, out_col, input ready);
    modport sink   (input valid, sum, out_row, out_col, output ready);
endinterface

>>> design/ternary_binary_tile_mac.sv
// Ternary by binary tile MAC, top level. Depends on tbm_pkg, tbm_in_if, tbm_out_if,
// tbm_delta, tbm_acc_mem and tbm_out_fifo.
//
// The block takes one item per clock unless the input stalls: an accumulate adds one k-byte
// step into all TILE_ROWS accumulators of a column, and a drain reads one accumulator out
// and clears it. The accumulators live in a single-port-write memory of TILE_COLS words;
// each item reads its column on the accepting edge and writes it back on the next edge,
// with a bypass so that back-to-back items on the same column see each other's updates.
// A drain result passes the read-modify-write stage and then waits in a two-entry queue.
// Any item stalls when the queued results plus the drain in flight, less a result being
// taken, fill the queue. Per-column valid bits make every accumulator read as zero after
// reset, so no clearing pass is needed and items are taken from the first cycle.
`timescale 1ns / 1ps

module ternary_binary_tile_mac #(
    parameter int TILE_ROWS = tbm_pkg::DEF_TILE_ROWS,
    parameter int TILE_COLS = tbm_pkg::DEF_TILE_COLS
) (
    input  logic       clk,
    input  logic       rst_n,
    tbm_in_if.sink     req,
    tbm_out_if.source  rsp
);
    import tbm_pkg::*;

    delta_t [TILE_ROWS-1:0] deltas;
    logic                   accept;
    logic                   push;
    result_t                result;
    logic [1:0]             fifo_count;
    logic                   pop;
    logic [2:0]             pending;

    assign accept    = req.valid && req.ready;
    assign pop       = rsp.valid && rsp.ready;
    assign pending   = 3'(fifo_count) + 3'(push) - 3'(pop);
    assign req.ready = (pending <= 3'd1);

    tbm_delta #(
        .TILE_ROWS (TILE_ROWS)
    ) u_delta (
        .a_pos  (req.a_pos),
        .a_neg  (req.a_neg),
        .b_neg  (req.b_neg),
        .deltas (deltas)
    );

    tbm_acc_mem #(
        .TILE_ROWS (TILE_ROWS),
        .TILE_COLS (TILE_COLS)
    ) u_acc_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (req.cmd),
        .col    (req.col),
        .row    (req.row),
        .deltas (deltas),
        .push   (push),
        .result (result)
    );

    tbm_out_fifo u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .data  (result),
        .rsp   (rsp),
        .count (fifo_count)
    );

    a_drain_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == CMD_DRAIN)) |=> push)
        else $error("accepted drain item produced no result");

    a_acc_gives_none: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == CMD_ACC)) |=> !push)
        else $error("accumulate item produced a result");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((fifo_count != 2'd2) || pop))
        else $error("result pushed into a full queue");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count != 2'd3)
        else $error("result queue count out of range");
endmodule

>>> design/tbm_delta.sv
// Per-row step values of one accumulate item: agreeing minus disagreeing elements.
// Depends on tbm_pkg (byte_delta, delta_t).
`timescale 1ns / 1ps

module tbm_delta #(
    parameter int TILE_ROWS = tbm_pkg::DEF_TILE_ROWS
) (
    input  logic [tbm_pkg::PLANE_W-1:0]          a_pos,
    input  logic [tbm_pkg::PLANE_W-1:0]          a_neg,
    input  logic [tbm_pkg::BYTE_W-1:0]           b_neg,
    output tbm_pkg::delta_t [TILE_ROWS-1:0]      deltas
);
    import tbm_pkg::*;

    for (genvar r = 0; r < TILE_ROWS; r++)
    begin : g_row
        if (r < PLANE_ROWS)
        begin : g_plane
            assign deltas[r] = byte_delta(a_pos[r*BYTE_W +: BYTE_W],
                                          a_neg[r*BYTE_W +: BYTE_W], b_neg);
        end
        else
        begin : g_zero
            // Rows past the plane fields see all-zero planes.
            assign deltas[r] = '0;
        end
    end
endmodule

>>> design/tbm_acc_mem.sv
// Accumulator memory, one word per column holding all tile rows, with a
// read-modify-write stage, write forwarding and per-column valid bits. Depends on tbm_pkg.
`timescale 1ns / 1ps

module tbm_acc_mem #(
    parameter int TILE_ROWS = tbm_pkg::DEF_TILE_ROWS,
    parameter int TILE_COLS = tbm_pkg::DEF_TILE_COLS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic                                 cmd,
    input  logic [tbm_pkg::COL_W-1:0]            col,
    input  logic [tbm_pkg::ROW_W-1:0]            row,
    input  tbm_pkg::delta_t [TILE_ROWS-1:0]      deltas,
    output logic                                 push,
    output tbm_pkg::result_t                     result
);
    import tbm_pkg::*;

    localparam int ADDR_W = $clog2(TILE_COLS);

    typedef acc_t [TILE_ROWS-1:0] word_t;

    word_t                   mem [TILE_COLS];
    logic [TILE_COLS-1:0]    vld_reg;

    logic                    s1_valid_reg;
    logic                    s1_cmd_reg;
    logic [COL_W-1:0]        s1_col_reg;
    logic [ROW_W-1:0]        s1_row_reg;
    logic                    s1_col_ok_reg;
    logic [ADDR_W-1:0]       s1_addr_reg;
    delta_t [TILE_ROWS-1:0]  s1_delta_reg;

    word_t                   rd_word_reg;
    logic                    rd_vld_reg;

    logic                    fwd_valid_reg;
    logic [ADDR_W-1:0]       fwd_addr_reg;
    word_t                   fwd_word_reg;

    logic                    col_ok;
    logic [ADDR_W-1:0]       addr;
    word_t                   old_word;
    word_t                   new_word;
    acc_t                    sum;
    logic                    wr_en;

    assign col_ok = (int'(col) < TILE_COLS);
    assign addr   = ADDR_W'(col);
    assign wr_en  = s1_valid_reg && s1_col_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            fwd_valid_reg <= wr_en;
            rd_vld_reg    <= vld_reg[addr];
            if (wr_en)
            begin
                vld_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg    <= cmd;
            s1_col_reg    <= col;
            s1_row_reg    <= row;
            s1_col_ok_reg <= col_ok;
            s1_addr_reg   <= addr;
            s1_delta_reg  <= deltas;
        end
        fwd_addr_reg <= s1_addr_reg;
        fwd_word_reg <= new_word;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_addr_reg] <= new_word;
        end
        rd_word_reg <= mem[addr];
    end

    // The memory returns the old word when the preceding item wrote the same
    // column on the edge of the read, so that write is taken from the bypass.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            old_word = fwd_word_reg;
        end
        else if (rd_vld_reg)
        begin
            old_word = rd_word_reg;
        end
        else
        begin
            old_word = '0;
        end

        sum = '0;
        for (int r = 0; r < TILE_ROWS; r++)
        begin
            if (s1_cmd_reg == CMD_DRAIN)
            begin
                if (int'(s1_row_reg) == r)
                begin
                    new_word[r] = '0;
                    if (s1_col_ok_reg)
                    begin
                        sum = old_word[r];
                    end
                end
                else
                begin
                    new_word[r] = old_word[r];
                end
            end
            else
            begin
                new_word[r] = old_word[r] + ACC_W'(s1_delta_reg[r]);
            end
        end
    end

    assign push       = s1_valid_reg && (s1_cmd_reg == CMD_DRAIN);
    assign result.sum = sum;
    assign result.row = s1_row_reg;
    assign result.col = s1_col_reg;
endmodule

>>> design/tbm_out_fifo.sv
// Two-entry result queue in front of the output channel.
// Depends on tbm_pkg (result_t) and tbm_out_if.
`timescale 1ns / 1ps

module tbm_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tbm_pkg::result_t  data,
    tbm_out_if.source         rsp,
    output logic [1:0]        count
);
    import tbm_pkg::*;

    result_t     entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;

    assign pop        = rsp.valid && rsp.ready;
    assign count_next = count_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= data;
        end
    end

    assign rsp.valid   = (count_reg != 2'd0);
    assign rsp.sum     = entry_reg[rd_ptr_reg].sum;
    assign rsp.out_row = entry_reg[rd_ptr_reg].row;
    assign rsp.out_col = entry_reg[rd_ptr_reg].col;
    assign count       = count_reg;
endmodule
